>>> design/ridcv_pkg.sv
// Shared types, constants and table functions for the resident ID check-digit validator.
// Used by ridcv_core, resident_id_checksum_validator_unit and ridcv_checker.
`default_nettype none

package ridcv_pkg;

	localparam int unsigned BODY_LEN = 17;
	localparam int unsigned MAX_POS  = 31;

	localparam logic [7:0] CHAR_ZERO    = 8'h30;
	localparam logic [7:0] CHAR_NINE    = 8'h39;
	localparam logic [7:0] CHAR_X       = 8'h58;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic [7:0] id_char;
		logic       is_last;
	} ridcv_in_t;

	typedef struct packed {
		logic        id_valid;
		logic [7:0]  expected_check;
		logic [13:0] birth_year;
		logic [6:0]  birth_month;
		logic [6:0]  birth_day;
		logic        is_male;
		logic [6:0]  region_code;
		logic        region_known;
	} ridcv_out_t;

	typedef struct packed {
		logic [4:0]  char_position;
		logic [3:0]  sum_mod_eleven;
		logic        bad_digit_seen;
		logic [13:0] year_acc;
		logic [6:0]  month_acc;
		logic [6:0]  day_acc;
		logic [6:0]  region_acc;
		logic        sex_bit;
	} ridcv_state_t;

	// ISO 7064 MOD 11-2 weights for body positions 0..16
	function automatic logic [3:0] weight_of(input logic [4:0] pos);
		logic [3:0] w;
		case (pos)
			5'd0, 5'd10:  w = 4'd7;
			5'd1, 5'd11:  w = 4'd9;
			5'd2, 5'd12:  w = 4'd10;
			5'd3, 5'd13:  w = 4'd5;
			5'd4, 5'd14:  w = 4'd8;
			5'd5, 5'd15:  w = 4'd4;
			5'd6, 5'd16:  w = 4'd2;
			5'd7:         w = 4'd1;
			5'd8:         w = 4'd6;
			5'd9:         w = 4'd3;
			default:      w = 4'd0;
		endcase
		return w;
	endfunction

	// p mod 11 for p <= 99: quotient by reciprocal 187/2048
	function automatic logic [3:0] mod11_small(input logic [6:0] p);
		logic [14:0] prod;
		logic [3:0]  q;
		logic [6:0]  r;
		prod = {8'b0, p} * 15'd187;
		q    = prod[14:11];
		r    = p - ({3'b0, q} * 7'd11);
		return r[3:0];
	endfunction

	function automatic logic [7:0] check_char(input logic [3:0] sum);
		logic [7:0] c;
		case (sum)
			4'd0:    c = 8'h31;
			4'd1:    c = 8'h30;
			4'd2:    c = CHAR_X;
			4'd3:    c = 8'h39;
			4'd4:    c = 8'h38;
			4'd5:    c = 8'h37;
			4'd6:    c = 8'h36;
			4'd7:    c = 8'h35;
			4'd8:    c = 8'h34;
			4'd9:    c = 8'h33;
			4'd10:   c = 8'h32;
			default: c = 8'h31;
		endcase
		return c;
	endfunction

	function automatic logic region_listed(input logic [6:0] code);
		logic hit;
		case (code)
			7'd11, 7'd12, 7'd13, 7'd14, 7'd15,
			7'd21, 7'd22, 7'd23,
			7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37,
			7'd41, 7'd42, 7'd43, 7'd44, 7'd45, 7'd46,
			7'd50, 7'd51, 7'd52, 7'd53, 7'd54,
			7'd61, 7'd62, 7'd63, 7'd64, 7'd65,
			7'd71, 7'd81, 7'd82: hit = 1'b1;
			default:             hit = 1'b0;
		endcase
		// 37 is not a listed province
		if (code == 7'd37) begin
			hit = 1'b0;
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

>>> design/ridcv_core.sv
// Per-character update of the check sum and field accumulators, and result formation.
// Pure combinational; depends on ridcv_pkg.
`default_nettype none

module ridcv_core
	import ridcv_pkg::*;
(
	input  wire ridcv_state_t st,
	input  wire ridcv_in_t    chr,
	output ridcv_state_t      st_next,
	output ridcv_out_t        res
);

	logic       is_digit;
	logic [3:0] digit;
	logic [6:0] prod;
	logic [3:0] prod_mod;
	logic [4:0] sum_raw;
	logic [3:0] sum_new;
	logic [4:0] pos;
	logic [7:0] upc;
	logic [7:0] expect_c;

	assign pos      = st.char_position;
	assign is_digit = (chr.id_char >= CHAR_ZERO) && (chr.id_char <= CHAR_NINE);
	assign digit    = is_digit ? chr.id_char[3:0] : 4'd0;
	assign prod     = {3'b0, digit} * {3'b0, weight_of(pos)};
	assign prod_mod = mod11_small(prod);
	assign sum_raw  = {1'b0, st.sum_mod_eleven} + {1'b0, prod_mod};
	assign sum_new  = (sum_raw >= 5'd11) ? 4'(sum_raw - 5'd11) : sum_raw[3:0];

	always_comb begin
		st_next = st;
		if (pos < 5'(BODY_LEN)) begin
			if (is_digit) begin
				st_next.sum_mod_eleven = sum_new;
			end else begin
				st_next.bad_digit_seen = 1'b1;
			end
			if (pos < 5'd2) begin
				st_next.region_acc = 7'(st.region_acc * 7'd10 + {3'b0, digit});
			end else if (pos >= 5'd6 && pos <= 5'd9) begin
				st_next.year_acc = 14'(st.year_acc * 14'd10 + {10'b0, digit});
			end else if (pos == 5'd10 || pos == 5'd11) begin
				st_next.month_acc = 7'(st.month_acc * 7'd10 + {3'b0, digit});
			end else if (pos == 5'd12 || pos == 5'd13) begin
				st_next.day_acc = 7'(st.day_acc * 7'd10 + {3'b0, digit});
			end else if (pos == 5'd16) begin
				st_next.sex_bit = digit[0];
			end
		end
		if (pos < 5'(MAX_POS)) begin
			st_next.char_position = pos + 5'd1;
		end
	end

	assign expect_c = check_char(st.sum_mod_eleven);
	assign upc = (chr.id_char >= CHAR_LOWER_A && chr.id_char <= CHAR_LOWER_Z) ?
		(chr.id_char - CASE_OFFSET) : chr.id_char;

	always_comb begin
		res.id_valid       = (pos == 5'(BODY_LEN)) && !st.bad_digit_seen && (upc == expect_c);
		res.expected_check = expect_c;
		res.birth_year     = st.year_acc;
		res.birth_month    = st.month_acc;
		res.birth_day      = st.day_acc;
		res.is_male        = st.sex_bit;
		res.region_code    = st.region_acc;
		res.region_known   = region_listed(st.region_acc);
	end

endmodule

`default_nettype wire

>>> design/resident_id_checksum_validator_unit.sv
// Top level of the resident ID check-digit validator: input register, state, result register.
// Depends on ridcv_pkg and ridcv_core.
`default_nettype none

// Takes one ASCII character word per cycle on the char channel; the word flagged
// is_last closes a number and yields one result word on the res channel once
// that character has passed the input register and the result register. The
// block holds one character in its input register and one result in its output
// register, so it keeps accepting characters while a result waits; the char
// channel stalls only when a last character meets a full, stalled result
// register. A wrong length or a non-digit in the body gives id_valid = 0, and
// all running state clears after each result.
module resident_id_checksum_validator_unit
	import ridcv_pkg::*;
(
	input  wire            clk,
	input  wire            arst_n,
	input  wire            char_valid,
	output logic           char_stall,
	input  wire ridcv_in_t char_data,
	output logic           res_valid,
	input  wire            res_stall,
	output ridcv_out_t     res_data
);

	logic         valid_s1;
	ridcv_in_t    data_s1;
	ridcv_state_t state_q;
	ridcv_state_t state_next;
	ridcv_out_t   res_next;
	logic         out_free;
	logic         s1_advance;
	logic         char_take;

	ridcv_core u_core (
		.st      (state_q),
		.chr     (data_s1),
		.st_next (state_next),
		.res     (res_next)
	);

	assign out_free   = !res_valid || !res_stall;
	assign s1_advance = valid_s1 && (!data_s1.is_last || out_free);
	assign char_stall = valid_s1 && !s1_advance;
	assign char_take  = char_valid && !char_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_take) begin
			valid_s1 <= 1'b1;
		end else if (s1_advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (char_take) begin
			data_s1 <= char_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_advance) begin
			if (data_s1.is_last) begin
				state_q <= '0;
			end else begin
				state_q <= state_next;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (out_free) begin
			res_valid <= s1_advance && data_s1.is_last;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_advance && data_s1.is_last) begin
			res_data <= res_next;
		end
	end

endmodule

`default_nettype wire

>>> design/ridcv_checker.sv
// Port-level checks for resident_id_checksum_validator_unit, attached by bind.
// Depends on ridcv_pkg.
`default_nettype none

module ridcv_checker
	import ridcv_pkg::*;
(
	input wire             clk,
	input wire             arst_n,
	input wire             char_valid,
	input wire             char_stall,
	input wire ridcv_in_t  char_data,
	input wire             res_valid,
	input wire             res_stall,
	input wire ridcv_out_t res_data
);

	// a stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result word changed while stalled");

	// check character always comes from the MOD 11-2 table
	a_check_legal: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.expected_check == CHAR_X) ||
			((res_data.expected_check >= CHAR_ZERO) && (res_data.expected_check <= CHAR_NINE)))
		else $error("expected check character out of table");

	// no result word appears without a character accepted in between
	a_res_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(char_valid && !char_stall && char_data.is_last, 2) ||
			$past(char_stall, 1))
		else $error("result word without a closing character");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !res_valid)
		else $error("result valid during reset");

endmodule

bind resident_id_checksum_validator_unit ridcv_checker u_ridcv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.char_valid (char_valid),
	.char_stall (char_stall),
	.char_data  (char_data),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);

`default_nettype wire
